// ===== design/tbmd_pkg.sv =====
// Package: types, codes and helpers shared by the Thrift message deframer.
`default_nettype none
package tbmd_pkg;

  typedef enum logic [3:0] {
    PH_VER   = 4'd0,
    PH_NLEN  = 4'd1,
    PH_NAME  = 4'd2,
    PH_SEQ   = 4'd3,
    PH_FTYPE = 4'd4,
    PH_FID   = 4'd5,
    PH_FVAL  = 4'd6,
    PH_SLEN  = 4'd7,
    PH_SBODY = 4'd8,
    PH_DONE  = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HDR   = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_SHORT = 2'd3
  } kind_e;

  localparam logic [7:0] TY_STOP     = 8'd0;
  localparam logic [7:0] TY_BOOL     = 8'd2;
  localparam logic [7:0] TY_BYTE     = 8'd3;
  localparam logic [7:0] TY_DOUBLE   = 8'd4;
  localparam logic [7:0] TY_I16      = 8'd6;
  localparam logic [7:0] TY_I32      = 8'd8;
  localparam logic [7:0] TY_U64      = 8'd9;
  localparam logic [7:0] TY_I64      = 8'd10;
  localparam logic [7:0] TY_LEN_LO   = 8'd11;
  localparam logic [7:0] TY_LEN_HI   = 8'd17;

  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         field_id;
    logic [7:0]         type_code;
    logic [15:0]        value_offset;
    logic [31:0]        value_length;
    logic signed [31:0] value;
    logic               run_end;
  } rec_t;

  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec_a;
    rec_t       rec_b;
  } push_t;

  // Value size in bytes of the fixed-width types, 0 for the rest.
  function automatic logic [3:0] fixed_size(input logic [7:0] t);
    logic [3:0] sz;
    case (t) inside
      TY_BOOL, TY_BYTE:            sz = 4'd1;
      TY_I16:                      sz = 4'd2;
      TY_I32:                      sz = 4'd4;
      TY_DOUBLE, TY_U64, TY_I64:   sz = 4'd8;
      default:                     sz = 4'd0;
    endcase
    return sz;
  endfunction

endpackage
`default_nettype wire

// ===== design/tbmd_if.sv =====
// Interfaces: byte request channel and record channel of the deframer.
`default_nettype none
interface tbmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;
  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface tbmd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         record_kind;
  logic [7:0]         field_id;
  logic [7:0]         type_code;
  logic [15:0]        value_offset;
  logic [31:0]        value_length;
  logic signed [31:0] value;
  logic               run_end;
  modport source (output valid, output record_kind, output field_id, output type_code,
                  output value_offset, output value_length, output value,
                  output run_end, input ready);
  modport sink   (input valid, input record_kind, input field_id, input type_code,
                  input value_offset, input value_length, input value,
                  input run_end, output ready);
endinterface
`default_nettype wire

// ===== design/tbmd_parse.sv =====
// Parser: message state registers and per-byte decode into up to two records.
`default_nettype none
module tbmd_parse #(
  parameter int unsigned MAX_ID      = 255,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          buffer_end_i,
  output tbmd_pkg::push_t    push_o
);
  import tbmd_pkg::*;

  localparam int unsigned OB = OFFSET_BITS;

  phase_e          phase_q, phase_d;
  logic [1:0]      biw_q, biw_d;
  logic [31:0]     acc_q, acc_d;
  logic [OB-1:0]   off_q, off_d;
  logic [31:0]     skip_q, skip_d;
  logic [7:0]      ctype_q, ctype_d;
  logic [15:0]     cid_q, cid_d;
  logic [7:0]      mtype_q, mtype_d;
  logic [OB-1:0]   noff_q, noff_d;
  logic [31:0]     nlen_q, nlen_d;

  logic [31:0]     acc_sh;
  logic            word_done;
  logic [1:0]      biw_inc;
  logic [OB-1:0]   off_inc;
  logic [3:0]      sz;
  logic [15:0]     id_use;
  logic            id_ok;
  logic            r0_v;
  rec_t            r0;
  logic            short_v;
  rec_t            rs;
  logic signed [31:0] fval;

  assign acc_sh    = {acc_q[23:0], data_byte_i};
  assign word_done = (biw_q == 2'd3);
  assign biw_inc   = biw_q + 2'd1;
  assign off_inc   = (phase_q != PH_DONE) ? off_q + OB'(1) : off_q;
  assign sz        = fixed_size(ctype_q);
  assign id_use    = (phase_q == PH_FID) ? acc_sh[15:0] : cid_q;
  assign id_ok     = ({1'b0, id_use} <= 17'(MAX_ID));

  always_comb begin
    case (sz)
      4'd1:    fval = {{24{acc_sh[7]}}, acc_sh[7:0]};
      4'd2:    fval = {16'd0, acc_sh[15:0]};
      4'd4:    fval = acc_sh;
      default: fval = '0;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    biw_d   = biw_q;
    acc_d   = acc_q;
    off_d   = off_inc;
    skip_d  = skip_q;
    ctype_d = ctype_q;
    cid_d   = cid_q;
    mtype_d = mtype_q;
    noff_d  = noff_q;
    nlen_d  = nlen_q;
    r0_v    = 1'b0;
    r0      = '0;
    r0.kind = KIND_FIELD;
    r0.field_id  = id_use[7:0];
    r0.type_code = ctype_q;

    unique case (phase_q)
      PH_VER: begin
        acc_d = acc_sh;
        biw_d = word_done ? 2'd0 : biw_inc;
        if (word_done) begin
          mtype_d = acc_sh[7:0];
          phase_d = PH_NLEN;
        end
      end
      PH_NLEN: begin
        acc_d = acc_sh;
        biw_d = word_done ? 2'd0 : biw_inc;
        if (word_done) begin
          nlen_d  = acc_sh;
          noff_d  = off_inc;
          skip_d  = acc_sh;
          phase_d = (acc_sh == 32'd0) ? PH_SEQ : PH_NAME;
        end
      end
      PH_NAME: begin
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) phase_d = PH_SEQ;
      end
      PH_SEQ: begin
        acc_d = acc_sh;
        biw_d = word_done ? 2'd0 : biw_inc;
        if (word_done) begin
          r0_v            = 1'b1;
          r0.kind         = KIND_HDR;
          r0.field_id     = 8'd0;
          r0.type_code    = mtype_q;
          r0.value_offset = 16'(noff_q);
          r0.value_length = nlen_q;
          r0.value        = acc_sh;
          phase_d         = PH_FTYPE;
        end
      end
      PH_FTYPE: begin
        ctype_d = data_byte_i;
        if (data_byte_i == TY_STOP) begin
          r0_v            = 1'b1;
          r0.kind         = KIND_DONE;
          r0.field_id     = 8'd0;
          r0.type_code    = 8'd0;
          r0.value_offset = 16'(off_inc);
          phase_d         = PH_DONE;
        end else begin
          acc_d   = '0;
          biw_d   = 2'd0;
          phase_d = PH_FID;
        end
      end
      PH_FID: begin
        if (biw_q == 2'd1) begin
          biw_d = 2'd0;
          cid_d = acc_sh[15:0];
          acc_d = '0;
          if (sz != 4'd0) begin
            skip_d  = 32'(sz);
            phase_d = PH_FVAL;
          end else if (ctype_q >= TY_LEN_LO && ctype_q <= TY_LEN_HI) begin
            phase_d = PH_SLEN;
          end else begin
            r0_v    = id_ok;
            phase_d = PH_FTYPE;
          end
        end else begin
          biw_d = biw_inc;
          acc_d = acc_sh;
        end
      end
      PH_FVAL: begin
        acc_d  = acc_sh;
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) begin
          r0_v            = id_ok;
          r0.value_offset = 16'(off_inc - OB'(sz));
          r0.value_length = 32'(sz);
          r0.value        = fval;
          phase_d         = PH_FTYPE;
        end
      end
      PH_SLEN: begin
        acc_d = acc_sh;
        biw_d = word_done ? 2'd0 : biw_inc;
        if (word_done) begin
          if (acc_sh == 32'd0) begin
            r0_v            = id_ok;
            r0.value_offset = 16'(off_inc);
            phase_d         = PH_FTYPE;
          end else begin
            skip_d  = acc_sh;
            phase_d = PH_SBODY;
          end
        end
      end
      PH_SBODY: begin
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) begin
          r0_v            = id_ok;
          r0.value_offset = 16'(off_inc - acc_q[OB-1:0]);
          r0.value_length = acc_q;
          phase_d         = PH_FTYPE;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    short_v    = buffer_end_i && (phase_d != PH_DONE);
    r0.run_end = !short_v;
    rs         = '0;
    rs.kind    = KIND_SHORT;
    rs.run_end = 1'b1;

    if (buffer_end_i) begin
      phase_d = PH_VER;
      biw_d   = '0;
      acc_d   = '0;
      off_d   = '0;
      skip_d  = '0;
      ctype_d = '0;
      cid_d   = '0;
      mtype_d = '0;
      noff_d  = '0;
      nlen_d  = '0;
    end
  end

  always_comb begin
    push_o = '0;
    if (fire_i) begin
      push_o.cnt   = {1'b0, r0_v} + {1'b0, short_v};
      push_o.rec_a = r0_v ? r0 : rs;
      push_o.rec_b = rs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VER;
      biw_q   <= '0;
      acc_q   <= '0;
      off_q   <= '0;
      skip_q  <= '0;
      ctype_q <= '0;
      cid_q   <= '0;
      mtype_q <= '0;
      noff_q  <= '0;
      nlen_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      biw_q   <= biw_d;
      acc_q   <= acc_d;
      off_q   <= off_d;
      skip_q  <= skip_d;
      ctype_q <= ctype_d;
      cid_q   <= cid_d;
      mtype_q <= mtype_d;
      noff_q  <= noff_d;
      nlen_q  <= nlen_d;
    end
  end

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && buffer_end_i |=> phase_q == PH_VER && off_q == '0)
    else $error("buffer end did not restart the parser");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !buffer_end_i && phase_q == PH_DONE |-> push_o.cnt == 2'd0)
    else $error("record produced after stop byte");

  a_short_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && push_o.cnt == 2'd2 |-> push_o.rec_b.kind == KIND_SHORT && !push_o.rec_a.run_end)
    else $error("second record is not a too-short record");

endmodule
`default_nettype wire

// ===== design/tbmd_rq.sv =====
// Record queue: takes up to two records per cycle, hands out one per cycle while pop_i is high.
`default_nettype none
module tbmd_rq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire tbmd_pkg::push_t           push_i,
  output logic                           room_o,
  output logic                           valid_o,
  input  wire logic                      pop_i,
  output tbmd_pkg::rec_t                 rec_o
);
  import tbmd_pkg::*;

  rec_t                mem_q [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_q, wr_d;
  logic [RQ_PTR_W-1:0] rd_q, rd_d;
  logic [RQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign rec_o   = mem_q[rd_q];

  assign wr_d  = wr_q + RQ_PTR_W'(push_i.cnt);
  assign rd_d  = rd_q + RQ_PTR_W'(pop);
  assign cnt_d = cnt_q + RQ_CNT_W'(push_i.cnt) - RQ_CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.rec_a;
    if (push_i.cnt == 2'd2) mem_q[wr_q + RQ_PTR_W'(1)] <= push_i.rec_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> {1'b0, cnt_q} + (RQ_CNT_W + 1)'(push_i.cnt)
      <= (RQ_CNT_W + 1)'(RQ_DEPTH))
    else $error("record queue overflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RQ_CNT_W'(RQ_DEPTH))
    else $error("record count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    RQ_PTR_W'(wr_q - rd_q) == RQ_PTR_W'(cnt_q))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// ===== design/thrift_binary_message_deframer_top.sv =====
// Top level of the Thrift binary message deframer.
//
//   channel  dir  payload                                               handshake
//   byte_i   in   data_byte, buffer_end                                 valid/ready
//   rec_o    out  record_kind, field_id, type_code, value_offset,       valid/ready
//                 value_length, value, run_end
//
// One byte request is taken per cycle while byte_i.ready is high; its records
// land in a four-entry queue the next cycle and leave one per cycle while
// rec_o.ready is high; a byte may yield two (a result and a too-short marker).
// byte_i.ready drops when the queue has room for fewer than two records.
// Reset clears the parser to expect a version word and empties the queue.
`default_nettype none
module thrift_binary_message_deframer_top #(
  parameter int unsigned MAX_ID      = 255,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  tbmd_in_if.sink       byte_i,
  tbmd_out_if.source    rec_o
);
  import tbmd_pkg::*;

  push_t push;
  rec_t  head;
  logic  room;
  logic  fire;

  assign byte_i.ready = room;
  assign fire         = byte_i.valid && room;

  tbmd_parse #(
    .MAX_ID      (MAX_ID),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (byte_i.data_byte),
    .buffer_end_i (byte_i.buffer_end),
    .push_o       (push)
  );

  tbmd_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (rec_o.valid),
    .pop_i   (rec_o.ready),
    .rec_o   (head)
  );

  assign rec_o.record_kind  = head.kind;
  assign rec_o.field_id     = head.field_id;
  assign rec_o.type_code    = head.type_code;
  assign rec_o.value_offset = head.value_offset;
  assign rec_o.value_length = head.value_length;
  assign rec_o.value        = head.value;
  assign rec_o.run_end      = head.run_end;

endmodule
`default_nettype wire
